// File: rtl/core/sma_pkg.sv
// shared types and constants for the six-channel moving-average filter
package sma_pkg;

  localparam int CH_N     = 6;
  localparam int SAMPLE_W = 16;
  localparam int USED_W   = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] mag_x;
    logic signed [SAMPLE_W-1:0] mag_y;
    logic signed [SAMPLE_W-1:0] mag_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_accel_x;
    logic signed [SAMPLE_W-1:0] avg_accel_y;
    logic signed [SAMPLE_W-1:0] avg_accel_z;
    logic signed [SAMPLE_W-1:0] avg_mag_x;
    logic signed [SAMPLE_W-1:0] avg_mag_y;
    logic signed [SAMPLE_W-1:0] avg_mag_z;
    logic        [USED_W-1:0]   samples_used;
  } out_beat_t;

  typedef logic [CH_N-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/sma_ring_mem.sv
// sample ring: one write port, one registered read port
module sma_ring_mem import sma_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic        clk,
  input  logic        we,
  input  logic [AW-1:0] waddr,
  input  sample_vec_t wdata,
  input  logic        re,
  input  logic [AW-1:0] raddr,
  output sample_vec_t rdata
);

  sample_vec_t mem [DEPTH];
  sample_vec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sma_div.sv
// six-lane signed divide by the slot count, one quotient bit per cycle
module sma_div import sma_pkg::*; #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [CH_N-1:0][SUM_W-1:0]     sums,
  input  logic [CNT_W-1:0]               divisor,
  output div_stat_t                      stat,
  output sample_vec_t                    quot
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [CH_N-1:0]               neg_r, neg_nxt;
  logic [CH_N-1:0][SUM_W-1:0]    quo_r, quo_nxt;
  logic [CH_N-1:0][CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]              dvs_r, dvs_nxt;

  always_comb begin
    logic [CNT_W:0] rem_w;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_w    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvs_nxt  = divisor;
      for (int c = 0; c < CH_N; c++) begin
        neg_nxt[c] = sums[c][SUM_W-1];
        quo_nxt[c] = sums[c][SUM_W-1] ? (~sums[c] + SUM_W'(1)) : sums[c];
        rem_nxt[c] = '0;
      end
    end else if (busy_r) begin
      for (int c = 0; c < CH_N; c++) begin
        rem_w = {rem_r[c], quo_r[c][SUM_W-1]};
        if (rem_w >= {1'b0, dvs_r}) begin
          rem_nxt[c] = CNT_W'(rem_w - {1'b0, dvs_r});
          quo_nxt[c] = {quo_r[c][SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_w[CNT_W-1:0];
          quo_nxt[c] = {quo_r[c][SUM_W-2:0], 1'b0};
        end
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(SUM_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_comb begin
    for (int c = 0; c < CH_N; c++) begin
      quot[c] = neg_r[c] ? (~quo_r[c][SAMPLE_W-1:0] + SAMPLE_W'(1))
                         : quo_r[c][SAMPLE_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/core/six_channel_moving_average_top.sv
// top level: sample ring control, slot accumulation and result register
//
// Each accepted beat is written into a ring of WINDOW slots and answered by one result
// beat holding the per-channel mean of the filled slots, truncated toward zero, and the
// slot count (low four bits). For each item the filled slots are read back one per cycle
// through the ring's single read port, then all six sums are divided in parallel by a
// restoring divider that retires one quotient bit per cycle. A new sample is accepted only
// once the previous one has reached the output register; that register holds a finished
// result while the next sample is being processed.
module six_channel_moving_average_top import sma_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  state_t                       state_r, state_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic                         filled_r, filled_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [CH_N-1:0][SUM_W-1:0]   acc_r, acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_beat_t                    out_data_r, out_data_nxt;

  logic        wr_en;
  logic        rd_en;
  sample_vec_t wr_vec;
  sample_vec_t rd_vec;
  logic        div_start;
  div_stat_t   div_stat;
  sample_vec_t quot;

  assign wr_en  = in_valid && in_ready;
  assign wr_vec = in_data;

  sma_ring_mem #(
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot_r),
    .wdata (wr_vec),
    .re    (rd_en),
    .raddr (rd_idx_r[SLOT_W-1:0]),
    .rdata (rd_vec)
  );

  sma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .sums    (acc_r),
    .divisor (count_r),
    .stat    (div_stat),
    .quot    (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    filled_nxt    = filled_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (slot_r == SLOT_W'(WINDOW - 1)) begin
            slot_nxt   = '0;
            filled_nxt = 1'b1;
            count_nxt  = CNT_W'(WINDOW);
          end else begin
            slot_nxt  = slot_r + SLOT_W'(1);
            count_nxt = filled_r ? CNT_W'(WINDOW) : CNT_W'(slot_r) + CNT_W'(1);
          end
          rd_idx_nxt = '0;
          acc_nxt    = '0;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rd_idx_r != count_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          for (int c = 0; c < CH_N; c++) begin
            acc_nxt[c] = acc_r[c] +
                         {{(SUM_W-SAMPLE_W){rd_vec[c][SAMPLE_W-1]}}, rd_vec[c]};
          end
        end
        if (rd_idx_r == count_r && !rd_vld_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{avg_accel_x:  quot[5],
                            avg_accel_y:  quot[4],
                            avg_accel_z:  quot[3],
                            avg_mag_x:    quot[2],
                            avg_mag_y:    quot[1],
                            avg_mag_z:    quot[0],
                            samples_used: USED_W'(count_r)};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r != '0 && count_r <= CNT_W'(WINDOW)))
    else $error("slot count out of range while busy");

  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (rd_idx_r <= count_r))
    else $error("ring read index ran past the slot count");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");
`endif

endmodule
